[hw/rtl/rbec_pkg.sv]
// Shared types, constants and helper functions for the RTC BCD / epoch converter.
// No dependencies; every other file of the block imports this package.
package rbec_pkg;

    // Pipeline depth, shared by both datapaths and the handshake control.
    localparam int unsigned STAGES = 10;

    typedef logic [STAGES-1:0] stage_en_t;

    typedef enum logic [1:0] {
        OUTCOME_OK       = 2'd0,
        OUTCOME_OSC_STOP = 2'd1,
        OUTCOME_BAD      = 2'd2
    } outcome_t;

    localparam logic KIND_DECODE = 1'b0;
    localparam logic KIND_ENCODE = 1'b1;

    localparam logic [11:0] YEAR_BASE      = 12'd2000;
    localparam logic [11:0] YEAR_CEIL      = 12'd2099;
    localparam logic [11:0] MIN_YEAR_RESET = 12'd2024;

    // Day numbers counted from 1970-01-01.
    localparam logic [15:0] DAYS_1996_MAR = 16'd9556;
    localparam logic [15:0] DAYS_1999_MAR = 16'd10651;
    localparam logic [15:0] DAYS_2000_JAN = 16'd10957;
    localparam logic [15:0] DAYS_2099_END = 16'd47481;

    localparam logic [16:0] SECS_PER_DAY  = 17'd86400;
    localparam logic [11:0] SECS_PER_HOUR = 12'd3600;
    localparam logic [10:0] DAYS_PER_QUAD = 11'd1461;

    // floor(2^k / divisor), k = width of the dividend
    localparam logic [15:0] RECIP_DAY  = 16'd49710;
    localparam logic [5:0]  RECIP_QUAD = 6'd44;
    localparam logic [5:0]  RECIP_HOUR = 6'd36;
    localparam logic [6:0]  RECIP_MIN  = 7'd68;

    typedef struct packed {
        outcome_t    outcome;
        logic [31:0] epoch;
    } dec_result_t;

    typedef struct packed {
        outcome_t   outcome;
        logic [6:0] seconds_bcd;
        logic [6:0] minutes_bcd;
        logic [5:0] hours_bcd;
        logic [2:0] weekday_bcd;
        logic [5:0] date_bcd;
        logic [4:0] month_bcd;
        logic [7:0] year_bcd;
    } enc_result_t;

    // Days from March 1 to the first day of month index mp (March = 0).
    function automatic logic [8:0] cum_days(input logic [3:0] mp);
        logic [8:0] d;
        case (mp)
            4'd0:    d = 9'd0;
            4'd1:    d = 9'd31;
            4'd2:    d = 9'd61;
            4'd3:    d = 9'd92;
            4'd4:    d = 9'd122;
            4'd5:    d = 9'd153;
            4'd6:    d = 9'd184;
            4'd7:    d = 9'd214;
            4'd8:    d = 9'd245;
            4'd9:    d = 9'd275;
            4'd10:   d = 9'd306;
            4'd11:   d = 9'd337;
            default: d = 9'd0;
        endcase
        return d;
    endfunction

    // Weight two nibbles as tens and units, digits above nine taken as is.
    function automatic logic [7:0] bcd_value(input logic [7:0] v);
        return {1'b0, v[7:4], 3'b000} + {3'b000, v[7:4], 1'b0} + {4'b0000, v[3:0]};
    endfunction

    // Binary below 100 to two BCD digits; tens by reciprocal 103/1024.
    function automatic logic [7:0] to_bcd(input logic [6:0] v);
        logic [13:0] prod;
        logic [3:0]  tens;
        logic [6:0]  units;
        prod  = {7'b0, v} * 14'd103;
        tens  = prod[13:10];
        units = v - ({tens, 3'b000} + {2'b00, tens, 1'b0});
        return {tens, units[3:0]};
    endfunction

endpackage

[hw/rtl/rbec_decode.sv]
// Decode datapath: BCD clock registers to UTC epoch seconds, STAGES deep.
// Depends on rbec_pkg; stage enables come from the top-level handshake control.
module rbec_decode (
    input  logic                 aclk,
    input  rbec_pkg::stage_en_t  stage_en,
    input  logic [7:0]           status_reg,
    input  logic [7:0]           seconds_reg,
    input  logic [7:0]           minutes_reg,
    input  logic [7:0]           hours_reg,
    input  logic [7:0]           date_reg,
    input  logic [7:0]           month_reg,
    input  logic [7:0]           year_reg,
    input  logic [11:0]          min_valid_year,
    output rbec_pkg::dec_result_t result
);
    import rbec_pkg::*;

    // stage 0: unpack BCD, range check
    logic [7:0]  sec_val, min_val, h12_val, h24_val, day_val, mon_val, yr_val;
    logic [4:0]  h12_mod;
    logic [5:0]  hr_val;
    logic [11:0] yr_full;
    logic        bad_next;

    logic       s1_osc_reg, s1_bad_reg;
    logic [6:0] s1_yoff_reg;
    logic [3:0] s1_mon_reg;
    logic [4:0] s1_day_reg, s1_hr_reg;
    logic [5:0] s1_min_reg, s1_sec_reg;

    always_comb begin
        sec_val = bcd_value({1'b0, seconds_reg[6:0]});
        min_val = bcd_value({1'b0, minutes_reg[6:0]});
        h12_val = bcd_value({3'b000, hours_reg[4:0]});
        h24_val = bcd_value({2'b00, hours_reg[5:0]});
        day_val = bcd_value({2'b00, date_reg[5:0]});
        mon_val = bcd_value({3'b000, month_reg[4:0]});
        yr_val  = bcd_value(year_reg);
        if (h12_val[4:0] >= 5'd24) begin
            h12_mod = h12_val[4:0] - 5'd24;
        end else if (h12_val[4:0] >= 5'd12) begin
            h12_mod = h12_val[4:0] - 5'd12;
        end else begin
            h12_mod = h12_val[4:0];
        end
        if (hours_reg[6]) begin
            hr_val = {1'b0, h12_mod + (hours_reg[5] ? 5'd12 : 5'd0)};
        end else begin
            hr_val = h24_val[5:0];
        end
        yr_full  = YEAR_BASE + {4'b0000, yr_val};
        bad_next = (yr_full < min_valid_year) || (yr_full > YEAR_CEIL) ||
                   (mon_val == 8'd0) || (mon_val > 8'd12) ||
                   (day_val == 8'd0) || (day_val > 8'd31) ||
                   (hr_val > 6'd23) || (min_val > 8'd59) || (sec_val > 8'd59);
    end

    always_ff @(posedge aclk) begin
        if (stage_en[0]) begin
            s1_osc_reg  <= status_reg[7];
            s1_bad_reg  <= bad_next;
            s1_yoff_reg <= yr_val[6:0];
            s1_mon_reg  <= mon_val[3:0];
            s1_day_reg  <= day_val[4:0];
            s1_hr_reg   <= hr_val[4:0];
            s1_min_reg  <= min_val[5:0];
            s1_sec_reg  <= sec_val[5:0];
        end
    end

    // stage 1: year index from 1999-03-01, day of March-based year, time of day
    logic       le2;
    logic [3:0] mp;
    logic       s2_osc_reg, s2_bad_reg;
    logic [6:0] s2_a_reg;
    logic [8:0] s2_doy_reg;
    logic [16:0] s2_tod_reg;

    always_comb begin
        le2 = (s1_mon_reg <= 4'd2);
        mp  = le2 ? s1_mon_reg + 4'd9 : s1_mon_reg - 4'd3;
    end

    always_ff @(posedge aclk) begin
        if (stage_en[1]) begin
            s2_osc_reg <= s1_osc_reg;
            s2_bad_reg <= s1_bad_reg;
            s2_a_reg   <= s1_yoff_reg + (le2 ? 7'd0 : 7'd1);
            s2_doy_reg <= cum_days(mp) + {4'b0000, s1_day_reg} - 9'd1;
            s2_tod_reg <= {12'b0, s1_hr_reg} * 17'd3600 + {11'b0, s1_min_reg} * 17'd60 +
                          {11'b0, s1_sec_reg};
        end
    end

    // stage 2: day number; no century correction needed inside 1999..2100
    logic [6:0]  a_plus3;
    logic        s3_osc_reg, s3_bad_reg;
    logic [15:0] s3_days_reg;
    logic [16:0] s3_tod_reg;

    assign a_plus3 = s2_a_reg + 7'd3;

    always_ff @(posedge aclk) begin
        if (stage_en[2]) begin
            s3_osc_reg  <= s2_osc_reg;
            s3_bad_reg  <= s2_bad_reg;
            s3_days_reg <= DAYS_1999_MAR + {9'b0, s2_a_reg} * 16'd365 +
                           {11'b0, a_plus3[6:2]} + {7'b0, s2_doy_reg};
            s3_tod_reg  <= s2_tod_reg;
        end
    end

    // stage 3: days to seconds
    logic        s4_osc_reg, s4_bad_reg;
    logic [31:0] s4_prod_reg;
    logic [16:0] s4_tod_reg;

    always_ff @(posedge aclk) begin
        if (stage_en[3]) begin
            s4_osc_reg  <= s3_osc_reg;
            s4_bad_reg  <= s3_bad_reg;
            s4_prod_reg <= {16'b0, s3_days_reg} * {15'b0, SECS_PER_DAY};
            s4_tod_reg  <= s3_tod_reg;
        end
    end

    // stage 4: final sum and outcome, then hold in the delay line
    dec_result_t res_next;
    dec_result_t res_reg [4:STAGES-1];

    always_comb begin
        if (s4_osc_reg) begin
            res_next.outcome = OUTCOME_OSC_STOP;
            res_next.epoch   = 32'd0;
        end else if (s4_bad_reg) begin
            res_next.outcome = OUTCOME_BAD;
            res_next.epoch   = 32'd0;
        end else begin
            res_next.outcome = OUTCOME_OK;
            res_next.epoch   = s4_prod_reg + {15'b0, s4_tod_reg};
        end
    end

    always_ff @(posedge aclk) begin
        if (stage_en[4]) begin
            res_reg[4] <= res_next;
        end
    end

    for (genvar i = 5; i < STAGES; i++) begin : g_delay
        always_ff @(posedge aclk) begin
            if (stage_en[i]) begin
                res_reg[i] <= res_reg[i-1];
            end
        end
    end

    assign result = res_reg[STAGES-1];

endmodule

[hw/rtl/rbec_encode.sv]
// Encode datapath: UTC epoch seconds to BCD clock registers, STAGES deep.
// Depends on rbec_pkg; divisions by constants use reciprocal multiply plus one correction.
module rbec_encode (
    input  logic                  aclk,
    input  rbec_pkg::stage_en_t   stage_en,
    input  logic [31:0]           epoch_in,
    output rbec_pkg::enc_result_t result
);
    import rbec_pkg::*;

    // stage 0: estimate of epoch / 86400
    logic [31:0] e1_reg;
    logic [47:0] p1_reg;

    always_ff @(posedge aclk) begin
        if (stage_en[0]) begin
            e1_reg <= epoch_in;
            p1_reg <= {16'b0, epoch_in} * {32'b0, RECIP_DAY};
        end
    end

    // stage 1: back-multiply the estimate
    logic [31:0] e2_reg, m2_reg;
    logic [15:0] q2_reg;

    always_ff @(posedge aclk) begin
        if (stage_en[1]) begin
            e2_reg <= e1_reg;
            q2_reg <= p1_reg[47:32];
            m2_reg <= {16'b0, p1_reg[47:32]} * {15'b0, SECS_PER_DAY};
        end
    end

    // stage 2: correct day count, second of day
    logic [31:0] rem_day;
    logic [15:0] days3_reg;
    logic [16:0] r3_reg;

    assign rem_day = e2_reg - m2_reg;

    always_ff @(posedge aclk) begin
        if (stage_en[2]) begin
            if (rem_day >= {15'b0, SECS_PER_DAY}) begin
                days3_reg <= q2_reg + 16'd1;
                r3_reg    <= rem_day[16:0] - SECS_PER_DAY;
            end else begin
                days3_reg <= q2_reg;
                r3_reg    <= rem_day[16:0];
            end
        end
    end

    // stage 3: range flag, estimates of 4-year cycle and hour
    logic [15:0] dq;
    logic        ok4_reg;
    logic [15:0] dq4_reg;
    logic [16:0] r4s_reg;
    logic [21:0] pq4_reg;
    logic [22:0] ph4_reg;

    assign dq = days3_reg - DAYS_1996_MAR;

    always_ff @(posedge aclk) begin
        if (stage_en[3]) begin
            ok4_reg <= (days3_reg >= DAYS_2000_JAN) && (days3_reg <= DAYS_2099_END);
            dq4_reg <= dq;
            r4s_reg <= r3_reg;
            pq4_reg <= {6'b0, dq} * {16'b0, RECIP_QUAD};
            ph4_reg <= {6'b0, r3_reg} * {17'b0, RECIP_HOUR};
        end
    end

    // stage 4: back-multiply both estimates
    logic        ok5_reg;
    logic [15:0] dq5_reg, mq5_reg;
    logic [16:0] r5_reg, mh5_reg;
    logic [5:0]  q4e5_reg, he5_reg;

    always_ff @(posedge aclk) begin
        if (stage_en[4]) begin
            ok5_reg  <= ok4_reg;
            dq5_reg  <= dq4_reg;
            r5_reg   <= r4s_reg;
            q4e5_reg <= pq4_reg[21:16];
            he5_reg  <= ph4_reg[22:17];
            mq5_reg  <= {10'b0, pq4_reg[21:16]} * {5'b0, DAYS_PER_QUAD};
            mh5_reg  <= {11'b0, ph4_reg[22:17]} * {5'b0, SECS_PER_HOUR};
        end
    end

    // stage 5: correct cycle and hour
    logic [15:0] rq;
    logic [16:0] rh;
    logic        ok6_reg;
    logic [5:0]  q4_6_reg, hr6_reg;
    logic [10:0] r4_6_reg;
    logic [11:0] r2_6_reg;

    assign rq = dq5_reg - mq5_reg;
    assign rh = r5_reg - mh5_reg;

    always_ff @(posedge aclk) begin
        if (stage_en[5]) begin
            ok6_reg <= ok5_reg;
            if (rq >= {5'b0, DAYS_PER_QUAD}) begin
                q4_6_reg <= q4e5_reg + 6'd1;
                r4_6_reg <= rq[10:0] - DAYS_PER_QUAD;
            end else begin
                q4_6_reg <= q4e5_reg;
                r4_6_reg <= rq[10:0];
            end
            if (rh >= {5'b0, SECS_PER_HOUR}) begin
                hr6_reg  <= he5_reg + 6'd1;
                r2_6_reg <= rh[11:0] - SECS_PER_HOUR;
            end else begin
                hr6_reg  <= he5_reg;
                r2_6_reg <= rh[11:0];
            end
        end
    end

    // stage 6: year inside the cycle (leap year last), minute estimate
    logic [1:0] yr_in;
    logic [8:0] doy;
    logic        ok7_reg;
    logic [5:0]  q4_7_reg, hr7_reg;
    logic [1:0]  yr_in7_reg;
    logic [8:0]  doy7_reg;
    logic [11:0] r2_7_reg;
    logic [18:0] pm7_reg;

    always_comb begin
        yr_in = 2'd0;
        doy   = r4_6_reg[8:0];
        if (r4_6_reg >= 11'd1095) begin
            yr_in = 2'd3;
            doy   = 9'(r4_6_reg - 11'd1095);
        end else if (r4_6_reg >= 11'd730) begin
            yr_in = 2'd2;
            doy   = 9'(r4_6_reg - 11'd730);
        end else if (r4_6_reg >= 11'd365) begin
            yr_in = 2'd1;
            doy   = 9'(r4_6_reg - 11'd365);
        end
    end

    always_ff @(posedge aclk) begin
        if (stage_en[6]) begin
            ok7_reg    <= ok6_reg;
            q4_7_reg   <= q4_6_reg;
            hr7_reg    <= hr6_reg;
            yr_in7_reg <= yr_in;
            doy7_reg   <= doy;
            r2_7_reg   <= r2_6_reg;
            pm7_reg    <= {7'b0, r2_6_reg} * {12'b0, RECIP_MIN};
        end
    end

    // stage 7: month index by threshold count, minute back-multiply
    logic [3:0] mp;
    logic        ok8_reg;
    logic [5:0]  q4_8_reg, hr8_reg, mest8_reg;
    logic [1:0]  yr_in8_reg;
    logic [8:0]  doy8_reg;
    logic [3:0]  mp8_reg;
    logic [11:0] r2_8_reg, mm8_reg;

    always_comb begin
        mp = 4'd0;
        for (int k = 1; k < 12; k++) begin
            if (doy7_reg >= cum_days(4'(k))) begin
                mp = mp + 4'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (stage_en[7]) begin
            ok8_reg    <= ok7_reg;
            q4_8_reg   <= q4_7_reg;
            hr8_reg    <= hr7_reg;
            yr_in8_reg <= yr_in7_reg;
            doy8_reg   <= doy7_reg;
            mp8_reg    <= mp;
            r2_8_reg   <= r2_7_reg;
            mest8_reg  <= pm7_reg[17:12];
            mm8_reg    <= {6'b0, pm7_reg[17:12]} * 12'd60;
        end
    end

    // stage 8: day, month, year offset, minute and second
    logic [8:0]  day_full;
    logic [3:0]  mon;
    logic [7:0]  yoff;
    logic [11:0] rs;
    logic        ok9_reg;
    logic [4:0]  hr9_reg, day9_reg;
    logic [3:0]  mon9_reg;
    logic [6:0]  yoff9_reg;
    logic [5:0]  min9_reg, sec9_reg;

    always_comb begin
        day_full = doy8_reg - cum_days(mp8_reg) + 9'd1;
        mon      = (mp8_reg < 4'd10) ? mp8_reg + 4'd3 : mp8_reg - 4'd9;
        yoff     = {q4_8_reg, 2'b00} + {6'b0, yr_in8_reg} +
                   {7'b0, (mon <= 4'd2)} - 8'd4;
        rs       = r2_8_reg - mm8_reg;
    end

    always_ff @(posedge aclk) begin
        if (stage_en[8]) begin
            ok9_reg   <= ok8_reg;
            hr9_reg   <= hr8_reg[4:0];
            day9_reg  <= day_full[4:0];
            mon9_reg  <= mon;
            yoff9_reg <= yoff[6:0];
            if (rs >= 12'd60) begin
                min9_reg <= mest8_reg + 6'd1;
                sec9_reg <= 6'(rs - 12'd60);
            end else begin
                min9_reg <= mest8_reg;
                sec9_reg <= rs[5:0];
            end
        end
    end

    // stage 9: BCD packing; outside 2000..2099 every field reads zero but the outcome, which reads bad.
    logic [7:0] sec_b, min_b, hr_b, day_b, mon_b, yr_b;
    enc_result_t res_next;
    enc_result_t res_reg;

    always_comb begin
        sec_b = to_bcd({1'b0, sec9_reg});
        min_b = to_bcd({1'b0, min9_reg});
        hr_b  = to_bcd({2'b00, hr9_reg});
        day_b = to_bcd({2'b00, day9_reg});
        mon_b = to_bcd({3'b000, mon9_reg});
        yr_b  = to_bcd(yoff9_reg);
        if (ok9_reg) begin
            res_next.outcome     = OUTCOME_OK;
            res_next.seconds_bcd = sec_b[6:0];
            res_next.minutes_bcd = min_b[6:0];
            res_next.hours_bcd   = hr_b[5:0];
            res_next.weekday_bcd = 3'd1;
            res_next.date_bcd    = day_b[5:0];
            res_next.month_bcd   = mon_b[4:0];
            res_next.year_bcd    = yr_b;
        end else begin
            res_next             = '0;
            res_next.outcome     = OUTCOME_BAD;
        end
    end

    always_ff @(posedge aclk) begin
        if (stage_en[9]) begin
            res_reg <= res_next;
        end
    end

    assign result = res_reg;

endmodule

[hw/rtl/rtc_bcd_epoch_converter.sv]
// Top level of the RTC BCD / Unix epoch converter: handshake control and output select.
// Depends on rbec_pkg, rbec_decode and rbec_encode.

// Each transaction either decodes real-time-clock BCD registers (kind 0) into
// UTC seconds since 1970, or encodes an epoch (kind 1) into BCD registers in
// 24-hour mode with weekday 1; valid years are 2000..2099, and decode also
// requires the year to be at least the min_valid_year register (2024 after
// reset). Both directions run through one 10-stage pipeline (STAGES), and one
// transaction is taken every cycle while the output is not stalled. The depth
// is set by the encode path, which divides by 86400, 1461, 3600 and 60 with
// reciprocal multiplies, each needing an estimate multiply, a back-multiply
// and a correction stage. Every stage carries its own valid bit and takes new
// data whenever it is empty or its successor moves, so bubbles close up and
// up to 10 transactions are held while m_ready is low; s_ready falls only
// when every stage is full.
// min_valid_year is written through cfg_we/cfg_wdata and should change only
// while the pipeline is empty.
module rtc_bcd_epoch_converter (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        cfg_we,
    input  logic [11:0] cfg_wdata,

    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_kind,
    input  logic [7:0]  s_status_reg,
    input  logic [7:0]  s_seconds_reg,
    input  logic [7:0]  s_minutes_reg,
    input  logic [7:0]  s_hours_reg,
    input  logic [7:0]  s_date_reg,
    input  logic [7:0]  s_month_reg,
    input  logic [7:0]  s_year_reg,
    input  logic [31:0] s_epoch_in,

    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_outcome,
    output logic [31:0] m_epoch_out,
    output logic [6:0]  m_seconds_bcd,
    output logic [6:0]  m_minutes_bcd,
    output logic [5:0]  m_hours_bcd,
    output logic [2:0]  m_weekday_bcd,
    output logic [5:0]  m_date_bcd,
    output logic [4:0]  m_month_bcd,
    output logic [7:0]  m_year_bcd
);
    import rbec_pkg::*;

    logic [11:0] min_year_reg;
    stage_en_t   valid_reg;
    stage_en_t   kind_reg;
    stage_en_t   adv;

    dec_result_t dec_res;
    enc_result_t enc_res;

    // Hold the configuration register; the user must write it only while idle, which the block does not enforce.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_year_reg <= MIN_YEAR_RESET;
        end else if (cfg_we) begin
            min_year_reg <= cfg_wdata;
        end
    end

    // A stage advances when it is empty or the stage after it advances;
    // the last stage advances when its result is taken.
    always_comb begin
        adv[STAGES-1] = !valid_reg[STAGES-1] || m_ready;
        for (int i = STAGES - 2; i >= 0; i--) begin
            adv[i] = !valid_reg[i] || adv[i+1];
        end
    end

    assign s_ready = adv[0];

    // Valid bits travel with the data.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            if (adv[0]) begin
                valid_reg[0] <= s_valid;
            end
            for (int i = 1; i < STAGES; i++) begin
                if (adv[i]) begin
                    valid_reg[i] <= valid_reg[i-1];
                end
            end
        end
    end

    // Carry the direction of each transaction alongside it.
    always_ff @(posedge aclk) begin
        if (adv[0]) begin
            kind_reg[0] <= s_kind;
        end
        for (int i = 1; i < STAGES; i++) begin
            if (adv[i]) begin
                kind_reg[i] <= kind_reg[i-1];
            end
        end
    end

    rbec_decode u_decode (
        .aclk           (aclk),
        .stage_en       (adv),
        .status_reg     (s_status_reg),
        .seconds_reg    (s_seconds_reg),
        .minutes_reg    (s_minutes_reg),
        .hours_reg      (s_hours_reg),
        .date_reg       (s_date_reg),
        .month_reg      (s_month_reg),
        .year_reg       (s_year_reg),
        .min_valid_year (min_year_reg),
        .result         (dec_res)
    );

    rbec_encode u_encode (
        .aclk     (aclk),
        .stage_en (adv),
        .epoch_in (s_epoch_in),
        .result   (enc_res)
    );

    assign m_valid = valid_reg[STAGES-1];

    // Select the side that matches the transaction; the other side's fields read zero.
    always_comb begin
        if (kind_reg[STAGES-1] == KIND_ENCODE) begin
            m_outcome     = enc_res.outcome;
            m_epoch_out   = 32'd0;
            m_seconds_bcd = enc_res.seconds_bcd;
            m_minutes_bcd = enc_res.minutes_bcd;
            m_hours_bcd   = enc_res.hours_bcd;
            m_weekday_bcd = enc_res.weekday_bcd;
            m_date_bcd    = enc_res.date_bcd;
            m_month_bcd   = enc_res.month_bcd;
            m_year_bcd    = enc_res.year_bcd;
        end else begin
            m_outcome     = dec_res.outcome;
            m_epoch_out   = dec_res.epoch;
            m_seconds_bcd = 7'd0;
            m_minutes_bcd = 7'd0;
            m_hours_bcd   = 6'd0;
            m_weekday_bcd = 3'd0;
            m_date_bcd    = 6'd0;
            m_month_bcd   = 5'd0;
            m_year_bcd    = 8'd0;
        end
    end

endmodule

[bench/rbec_scoreboard.sv]
// Transaction types, the converter predictor and the result scoreboard for the bench.
// Depends on rbec_pkg for outcome_t, the kind codes and the year constants.
package rbec_bench_pkg;
    timeunit 1ns;
    timeprecision 1ps;

    import rbec_pkg::*;

    typedef struct packed {
        logic        kind;
        logic [7:0]  status_reg;
        logic [7:0]  seconds_reg;
        logic [7:0]  minutes_reg;
        logic [7:0]  hours_reg;
        logic [7:0]  date_reg;
        logic [7:0]  month_reg;
        logic [7:0]  year_reg;
        logic [31:0] epoch_in;
    } rtc_request_t;

    typedef struct packed {
        outcome_t    outcome;
        logic [31:0] epoch_out;
        logic [6:0]  seconds_bcd;
        logic [6:0]  minutes_bcd;
        logic [5:0]  hours_bcd;
        logic [2:0]  weekday_bcd;
        logic [5:0]  date_bcd;
        logic [4:0]  month_bcd;
        logic [7:0]  year_bcd;
    } rtc_result_t;

    localparam int unsigned UNIX_DAY_OFFSET = 719468;
    localparam int unsigned ERA_DAYS        = 146097;

    // Two nibbles weighted as tens and units; digits above nine count as is.
    function automatic int unsigned digit_weight(input logic [7:0] v);
        return int'(v[7:4]) * 10 + int'(v[3:0]);
    endfunction

    // Binary 0..99 to two BCD digits.
    function automatic logic [7:0] pack_digits(input int unsigned v);
        logic [7:0] d;
        d[7:4] = 4'(v / 10);
        d[3:0] = 4'(v % 10);
        return d;
    endfunction

    class rbec_scoreboard;
        rtc_result_t awaited[$];
        logic [11:0] min_year;
        int unsigned errors;

        function new();
            min_year = MIN_YEAR_RESET;
            errors   = 0;
        endfunction

        function void set_min_year(input logic [11:0] year);
            min_year = year;
        endfunction

        function int unsigned pending();
            return awaited.size();
        endfunction

        // Days since 1970-01-01 of a proleptic Gregorian date, year >= 1999.
        function int unsigned days_from_date(input int unsigned y, input int unsigned m,
                                             input int unsigned d);
            int unsigned yy, era, yoe, mp, doy, doe;
            yy  = (m <= 2) ? y - 1 : y;
            era = yy / 400;
            yoe = yy - era * 400;
            mp  = (m > 2) ? m - 3 : m + 9;
            doy = (153 * mp + 2) / 5 + d - 1;
            doe = yoe * 365 + yoe / 4 - yoe / 100 + doy;
            return era * ERA_DAYS + doe - UNIX_DAY_OFFSET;
        endfunction

        function rtc_result_t convert(input rtc_request_t req);
            rtc_result_t res;
            int unsigned sec, mn, hr, day, mon, yr;
            int unsigned days, era, doe, yoe, doy, mp;
            longint unsigned total, e;
            logic [7:0] bcd;
            res = '0;
            res.outcome = OUTCOME_OK;
            if (req.kind == KIND_DECODE) begin
                if (req.status_reg[7]) begin
                    res.outcome = OUTCOME_OSC_STOP;
                    return res;
                end
                sec = digit_weight({1'b0, req.seconds_reg[6:0]});
                mn  = digit_weight({1'b0, req.minutes_reg[6:0]});
                if (req.hours_reg[6]) begin
                    hr = digit_weight({3'b000, req.hours_reg[4:0]}) % 12;
                    if (req.hours_reg[5])
                        hr += 12;
                end else begin
                    hr = digit_weight({2'b00, req.hours_reg[5:0]});
                end
                day = digit_weight({2'b00, req.date_reg[5:0]});
                mon = digit_weight({3'b000, req.month_reg[4:0]});
                yr  = int'(YEAR_BASE) + digit_weight(req.year_reg);
                if (yr < int'(min_year) || yr > int'(YEAR_CEIL) || mon < 1 || mon > 12 ||
                    day < 1 || day > 31 || hr > 23 || mn > 59 || sec > 59) begin
                    res.outcome = OUTCOME_BAD;
                    return res;
                end
                total = longint'(days_from_date(yr, mon, day)) * 86400 +
                        longint'(hr) * 3600 + longint'(mn) * 60 + longint'(sec);
                res.epoch_out = total[31:0];
            end else begin
                e   = req.epoch_in;
                sec = int'(e % 60);
                e   = e / 60;
                mn  = int'(e % 60);
                e   = e / 60;
                hr  = int'(e % 24);
                e   = e / 24;
                days = int'(e) + UNIX_DAY_OFFSET;
                era  = days / ERA_DAYS;
                doe  = days - era * ERA_DAYS;
                yoe  = (doe - doe / 1460 + doe / 36524 - doe / 146096) / 365;
                yr   = yoe + era * 400;
                doy  = doe - (365 * yoe + yoe / 4 - yoe / 100);
                mp   = (5 * doy + 2) / 153;
                day  = doy - (153 * mp + 2) / 5 + 1;
                mon  = (mp < 10) ? mp + 3 : mp - 9;
                if (mon <= 2)
                    yr += 1;
                if (yr < int'(YEAR_BASE) || yr > int'(YEAR_CEIL)) begin
                    res.outcome = OUTCOME_BAD;
                    return res;
                end
                bcd = pack_digits(sec);
                res.seconds_bcd = bcd[6:0];
                bcd = pack_digits(mn);
                res.minutes_bcd = bcd[6:0];
                bcd = pack_digits(hr);
                res.hours_bcd   = bcd[5:0];
                res.weekday_bcd = 3'd1;
                bcd = pack_digits(day);
                res.date_bcd    = bcd[5:0];
                bcd = pack_digits(mon);
                res.month_bcd   = bcd[4:0];
                res.year_bcd    = pack_digits(yr - int'(YEAR_BASE));
            end
            return res;
        endfunction

        function void note_request(input rtc_request_t req);
            awaited.push_back(convert(req));
        endfunction

        function void compare(input string field, input logic [31:0] want,
                              input logic [31:0] got);
            if (want !== got) begin
                $display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
                errors++;
            end
        endfunction

        function void check_result(input rtc_result_t got);
            rtc_result_t want;
            if (awaited.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual %h", $time, got);
                errors++;
                return;
            end
            want = awaited.pop_front();
            compare("outcome", want.outcome, got.outcome);
            compare("epoch_out", want.epoch_out, got.epoch_out);
            compare("seconds_bcd", want.seconds_bcd, got.seconds_bcd);
            compare("minutes_bcd", want.minutes_bcd, got.minutes_bcd);
            compare("hours_bcd", want.hours_bcd, got.hours_bcd);
            compare("weekday_bcd", want.weekday_bcd, got.weekday_bcd);
            compare("date_bcd", want.date_bcd, got.date_bcd);
            compare("month_bcd", want.month_bcd, got.month_bcd);
            compare("year_bcd", want.year_bcd, got.year_bcd);
        endfunction
    endclass

endpackage

[bench/testbench.sv]
// Bench top for the RTC BCD / epoch converter: clock, reset, drivers, monitors, watchdog.
// Depends on rbec_pkg, rbec_bench_pkg (scoreboard) and the rtc_bcd_epoch_converter RTL.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import rbec_pkg::*;
    import rbec_bench_pkg::*;

    // The watchdog fails the run when nothing is accepted on either side for this
    // long. The slowest correct stretch is a sender gap plus the pipeline plus a
    // choked receiver or a configuration drain; the limit takes it many times over.
    localparam int unsigned WATCHDOG_LIMIT = 2000;
    localparam int unsigned RANDOM_PER_PHASE = 120;
    localparam int unsigned EPOCH_2000 = 32'd946684800;
    localparam int unsigned EPOCH_2099_END = 32'd4102444799;

    typedef enum logic [1:0] {
        RX_OPEN,
        RX_TOGGLE,
        RX_COIN,
        RX_CHOKE
    } rx_mode_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_we = 1'b0;
    logic [11:0] cfg_wdata = '0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic        s_kind = 1'b0;
    logic [7:0]  s_status_reg = '0;
    logic [7:0]  s_seconds_reg = '0;
    logic [7:0]  s_minutes_reg = '0;
    logic [7:0]  s_hours_reg = '0;
    logic [7:0]  s_date_reg = '0;
    logic [7:0]  s_month_reg = '0;
    logic [7:0]  s_year_reg = '0;
    logic [31:0] s_epoch_in = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [1:0]  m_outcome;
    logic [31:0] m_epoch_out;
    logic [6:0]  m_seconds_bcd;
    logic [6:0]  m_minutes_bcd;
    logic [5:0]  m_hours_bcd;
    logic [2:0]  m_weekday_bcd;
    logic [5:0]  m_date_bcd;
    logic [4:0]  m_month_bcd;
    logic [7:0]  m_year_bcd;

    rx_mode_t    rx_mode = RX_OPEN;
    int unsigned rx_span = 0;
    int unsigned idle_cycles = 0;

    rbec_scoreboard sb = new();

    rtc_bcd_epoch_converter i_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_kind        (s_kind),
        .s_status_reg  (s_status_reg),
        .s_seconds_reg (s_seconds_reg),
        .s_minutes_reg (s_minutes_reg),
        .s_hours_reg   (s_hours_reg),
        .s_date_reg    (s_date_reg),
        .s_month_reg   (s_month_reg),
        .s_year_reg    (s_year_reg),
        .s_epoch_in    (s_epoch_in),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_outcome     (m_outcome),
        .m_epoch_out   (m_epoch_out),
        .m_seconds_bcd (m_seconds_bcd),
        .m_minutes_bcd (m_minutes_bcd),
        .m_hours_bcd   (m_hours_bcd),
        .m_weekday_bcd (m_weekday_bcd),
        .m_date_bcd    (m_date_bcd),
        .m_month_bcd   (m_month_bcd),
        .m_year_bcd    (m_year_bcd)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // Receiver backpressure: switch between open, toggling, coin-flip and
    // choked spans of random length so stalls land on every pipeline fill level.
    always @(posedge aclk) begin
        if (rx_span == 0) begin
            rx_mode <= rx_mode_t'($urandom_range(0, 3));
            rx_span <= $urandom_range(20, 150);
        end else begin
            rx_span <= rx_span - 1;
        end
        case (rx_mode)
            RX_OPEN:   m_ready <= 1'b1;
            RX_TOGGLE: m_ready <= ~m_ready;
            RX_COIN:   m_ready <= 1'($urandom_range(0, 1));
            default:   m_ready <= (rx_span[3:0] < 4'd3);
        endcase
    end

    // Result monitor: everything read here is the pre-edge value.
    always @(posedge aclk) begin
        rtc_result_t got;
        if (aresetn && m_valid && m_ready) begin
            got.outcome     = outcome_t'(m_outcome);
            got.epoch_out   = m_epoch_out;
            got.seconds_bcd = m_seconds_bcd;
            got.minutes_bcd = m_minutes_bcd;
            got.hours_bcd   = m_hours_bcd;
            got.weekday_bcd = m_weekday_bcd;
            got.date_bcd    = m_date_bcd;
            got.month_bcd   = m_month_bcd;
            got.year_bcd    = m_year_bcd;
            sb.check_result(got);
        end
    end

    // Watchdog: count cycles with no transaction on either channel.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    // Present one request and hold it until accepted; record it at the
    // accepting edge so the expectation exists before any wait for idle.
    task automatic send_item(input rtc_request_t req);
        s_valid       <= 1'b1;
        s_kind        <= req.kind;
        s_status_reg  <= req.status_reg;
        s_seconds_reg <= req.seconds_reg;
        s_minutes_reg <= req.minutes_reg;
        s_hours_reg   <= req.hours_reg;
        s_date_reg    <= req.date_reg;
        s_month_reg   <= req.month_reg;
        s_year_reg    <= req.year_reg;
        s_epoch_in    <= req.epoch_in;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        sb.note_request(req);
    endtask

    // Drain: block until every outstanding result has come back.
    task automatic wait_idle();
        do
            @(posedge aclk);
        while (sb.pending() != 0);
    endtask

    // Change the year floor only with an empty pipeline.
    task automatic write_min_year(input logic [11:0] year);
        wait_idle();
        cfg_we    <= 1'b1;
        cfg_wdata <= year;
        @(posedge aclk);
        cfg_we <= 1'b0;
        sb.set_min_year(year);
    endtask

    function automatic rtc_request_t decode_req(input logic [7:0] st, input logic [7:0] sec,
                                                input logic [7:0] mn, input logic [7:0] hr,
                                                input logic [7:0] day, input logic [7:0] mon,
                                                input logic [7:0] yr);
        rtc_request_t req;
        req = '{kind: KIND_DECODE, status_reg: st, seconds_reg: sec, minutes_reg: mn,
                hours_reg: hr, date_reg: day, month_reg: mon, year_reg: yr, epoch_in: '0};
        return req;
    endfunction

    function automatic rtc_request_t encode_req(input logic [31:0] e);
        rtc_request_t req;
        req = '0;
        req.kind = KIND_ENCODE;
        req.epoch_in = e;
        return req;
    endfunction

    // Mostly well-formed register sets (random content, flag bits random),
    // then raw noise, in-range epochs and arbitrary epochs.
    function automatic rtc_request_t random_request();
        rtc_request_t req;
        int unsigned pick, lo, off, h;
        logic [7:0] d;
        req.kind        = 1'($urandom_range(0, 1));
        req.status_reg  = 8'($urandom);
        req.seconds_reg = 8'($urandom);
        req.minutes_reg = 8'($urandom);
        req.hours_reg   = 8'($urandom);
        req.date_reg    = 8'($urandom);
        req.month_reg   = 8'($urandom);
        req.year_reg    = 8'($urandom);
        req.epoch_in    = $urandom;
        pick = $urandom_range(0, 99);
        if (pick < 45) begin
            req.kind = KIND_DECODE;
            req.status_reg[7] = ($urandom_range(0, 15) == 0);
            d = pack_digits($urandom_range(0, 59));
            req.seconds_reg[6:0] = d[6:0];
            d = pack_digits($urandom_range(0, 59));
            req.minutes_reg[6:0] = d[6:0];
            if ($urandom_range(0, 1) != 0) begin
                // 12-hour mode: hour 1..12 with PM bit
                d = pack_digits($urandom_range(1, 12));
                req.hours_reg[6]   = 1'b1;
                req.hours_reg[4:0] = d[4:0];
            end else begin
                h = $urandom_range(0, 23);
                d = pack_digits(h);
                req.hours_reg[6]   = 1'b0;
                req.hours_reg[5:0] = d[5:0];
            end
            d = pack_digits($urandom_range(1, 31));
            req.date_reg[5:0] = d[5:0];
            d = pack_digits($urandom_range(1, 12));
            req.month_reg[4:0] = d[4:0];
            lo  = int'(sb.min_year) - int'(YEAR_BASE);
            off = $urandom_range(lo, 99);
            // Probe just below the floor now and then.
            if (lo > 0 && $urandom_range(0, 9) == 0)
                off = lo - 1;
            req.year_reg = pack_digits(off);
        end else if (pick < 55) begin
            req.kind = KIND_DECODE;
        end else if (pick < 85) begin
            req.kind = KIND_ENCODE;
            case ($urandom_range(0, 7))
                0:       req.epoch_in = EPOCH_2000 + $urandom_range(0, 200000);
                1:       req.epoch_in = EPOCH_2099_END - $urandom_range(0, 200000);
                default: req.epoch_in = $urandom_range(EPOCH_2000, EPOCH_2099_END);
            endcase
        end else begin
            req.kind = KIND_ENCODE;
        end
        return req;
    endfunction

    // Sender bursts of random length, random gaps, sometimes back to back.
    task automatic run_random(input int unsigned count);
        int unsigned left, burst, gap;
        rtc_request_t req;
        left = count;
        while (left != 0) begin
            burst = $urandom_range(1, 24);
            if (burst > left)
                burst = left;
            repeat (burst) begin
                req = random_request();
                send_item(req);
            end
            left -= burst;
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
            // Drop valid only when an edge follows before the next raise.
            if (gap != 0 || left == 0)
                s_valid <= 1'b0;
            repeat (gap)
                @(posedge aclk);
        end
    endtask

    initial begin
        rtc_request_t plan[$];

        repeat (12)
            @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed part, run with the reset year floor of 2024.
        plan.push_back(decode_req(8'h80, 8'h00, 8'h00, 8'h00, 8'h01, 8'h01, 8'h24)); // osc stop
        plan.push_back(decode_req(8'h7F, 8'h00, 8'h00, 8'h00, 8'h01, 8'h01, 8'h24)); // other status bits
        plan.push_back(decode_req(8'h00, 8'h59, 8'h59, 8'h23, 8'h31, 8'h12, 8'h99)); // last second
        plan.push_back(decode_req(8'h00, 8'hD9, 8'hD9, 8'h83, 8'hF1, 8'hF2, 8'h99)); // flag bits
        plan.push_back(decode_req(8'h00, 8'h00, 8'h00, 8'h52, 8'h15, 8'h06, 8'h30)); // 12 AM
        plan.push_back(decode_req(8'h00, 8'h00, 8'h00, 8'h72, 8'h15, 8'h06, 8'h30)); // 12 PM
        plan.push_back(decode_req(8'h00, 8'h30, 8'h45, 8'h71, 8'h15, 8'h06, 8'h30)); // 11 PM
        plan.push_back(decode_req(8'h00, 8'h00, 8'h00, 8'h5F, 8'h15, 8'h06, 8'h30)); // non-BCD 12h
        plan.push_back(decode_req(8'h00, 8'h00, 8'h00, 8'h00, 8'h31, 8'h12, 8'h23)); // below floor
        plan.push_back(decode_req(8'h00, 8'h00, 8'h00, 8'h00, 8'h01, 8'h00, 8'h50)); // month 0
        plan.push_back(decode_req(8'h00, 8'h00, 8'h00, 8'h00, 8'h01, 8'h13, 8'h50)); // month 13
        plan.push_back(decode_req(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h05, 8'h50)); // day 0
        plan.push_back(decode_req(8'h00, 8'h00, 8'h00, 8'h00, 8'h32, 8'h05, 8'h50)); // day 32
        plan.push_back(decode_req(8'h00, 8'h00, 8'h00, 8'h24, 8'h10, 8'h05, 8'h50)); // hour 24
        plan.push_back(decode_req(8'h00, 8'h00, 8'h60, 8'h10, 8'h10, 8'h05, 8'h50)); // minute 60
        plan.push_back(decode_req(8'h00, 8'h60, 8'h00, 8'h10, 8'h10, 8'h05, 8'h50)); // second 60
        plan.push_back(decode_req(8'h00, 8'h1F, 8'h00, 8'h10, 8'h10, 8'h05, 8'h50)); // non-BCD ok
        plan.push_back(decode_req(8'h00, 8'h00, 8'h00, 8'h00, 8'h01, 8'h01, 8'hFF)); // year nibbles
        plan.push_back(decode_req(8'h00, 8'h00, 8'h00, 8'h12, 8'h31, 8'h02, 8'h24)); // Feb 31 rolls
        plan.push_back(encode_req(32'd0));
        plan.push_back(encode_req(EPOCH_2000 - 1));
        plan.push_back(encode_req(EPOCH_2000));
        plan.push_back(encode_req(EPOCH_2099_END));
        plan.push_back(encode_req(EPOCH_2099_END + 1));
        plan.push_back(encode_req(32'hFFFF_FFFF));
        // The first random transaction follows the directed ones back to back.
        foreach (plan[i])
            send_item(plan[i]);

        // Random phases. Each floor change first drains the pipeline, which
        // also makes the sender pause until every expected result is back.
        run_random(RANDOM_PER_PHASE);
        write_min_year(YEAR_BASE);
        run_random(RANDOM_PER_PHASE);
        write_min_year(YEAR_CEIL);
        run_random(RANDOM_PER_PHASE);
        write_min_year(12'($urandom_range(2001, 2098)));
        run_random(RANDOM_PER_PHASE);
        write_min_year(MIN_YEAR_RESET);
        run_random(RANDOM_PER_PHASE);

        // Drain, then keep clocking so that any stray results can still show up.
        wait_idle();
        repeat (STAGES + 4)
            @(posedge aclk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

[sim.f]
hw/rtl/rbec_pkg.sv
hw/rtl/rbec_decode.sv
hw/rtl/rbec_encode.sv
hw/rtl/rtc_bcd_epoch_converter.sv
bench/rbec_scoreboard.sv
bench/testbench.sv
